// ----- hdl/bba_pkg.sv -----
// Shared field widths, codes and register reset values of the bitmap block allocator.
package bba_pkg;

   localparam int MODE_W   = 2;
   localparam int IDX_W    = 12;
   localparam int REG_W    = 13;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 1;

   localparam logic [REG_W-1:0] TOTAL_RESET    = 13'd4096;
   localparam logic [REG_W-1:0] RESERVED_RESET = 13'd0;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_FORMAT = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NORES = 2'd1,
      ST_INVAL = 2'd2
   } status_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_TOTAL    = 1'b0,
      CSR_RESERVED = 1'b1
   } csr_index_type;

endpackage

// ----- hdl/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/bitmap_block_allocator.sv -----
// First-fit bitmap block allocator: one used bit per block, kept in a word-wide bitmap RAM,
// with a running free count. Allocate scans the bitmap one RAM word per cycle from word 0.
// Free splits the index by a constant multiply, then reads, checks and writes back the bitmap word.
// Format rewrites every bitmap word, one per cycle. An unknown mode, an out-of-range free or
// an allocate with a total of zero goes straight to the response. After reset the block runs
// a clearing pass over every bitmap word before it takes its first item; configuration writes
// are taken at any time, and a format must follow a configuration change. A finished result
// sits in an output register, so the block takes the next item while that result waits.
module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 64
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bba_pkg::MODE_W-1:0]     req_mode,
   input  logic [bba_pkg::IDX_W-1:0]      req_block_index,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bba_pkg::IDX_W-1:0]      rsp_allocated_index,
   output logic [bba_pkg::REG_W-1:0]      rsp_free_count,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bba_pkg::CSR_W-1:0]      csr_index,
   input  logic [bba_pkg::REG_W-1:0]      csr_wdata
);

   localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = bba_pkg::IDX_W;
   localparam int REG_W     = bba_pkg::REG_W;
   localparam int CMP_W     = CNT_W > REG_W ? CNT_W : REG_W;
   // word = (index * DIV_M) >> DIV_SH, exact for every IDX_W-bit index
   localparam int DIV_SH    = IDX_W + BIT_W;
   localparam int DIV_M     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W    = IDX_W + DIV_SH + 1;

   localparam logic [CNT_W-1:0]   MAX_C  = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0]   WB_C   = CNT_W'(WORD_BITS);
   localparam logic [WADDR_W-1:0] LAST_W = WADDR_W'(NUM_WORDS - 1);

   typedef enum logic [6:0] {
      S_SWEEP    = 7'b0000001,
      S_IDLE     = 7'b0000010,
      S_ALLOC    = 7'b0000100,
      S_FREE_DIV = 7'b0001000,
      S_FREE_RD  = 7'b0010000,
      S_FREE_CHK = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [WADDR_W-1:0]            word_ff, word_in;
   logic [CNT_W-1:0]              base_ff, base_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [BIT_W-1:0]              bitpos_ff, bitpos_in;
   logic [CNT_W-1:0]              free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]              sweep_res_ff, sweep_res_in;
   logic                          fmt_ff, fmt_in;
   logic [bba_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [CNT_W-1:0]              grant_ff, grant_in;
   logic [REG_W-1:0]              total_ff, total_in;
   logic [REG_W-1:0]              reserved_ff, reserved_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]              rsp_index_ff, rsp_index_in;
   logic [REG_W-1:0]              rsp_count_ff, rsp_count_in;

   logic                          ram_wr_en;
   logic [WADDR_W-1:0]            ram_wr_addr;
   logic [WORD_BITS-1:0]          ram_wr_data;
   logic                          ram_rd_en;
   logic [WADDR_W-1:0]            ram_rd_addr;
   logic [WORD_BITS-1:0]          ram_rd_data;

   logic [CNT_W-1:0]              total_eff;
   logic [CNT_W-1:0]              res_eff;
   logic [CNT_W-1:0]              fmt_count;
   logic [CNT_W-1:0]              rem_src;
   logic [CNT_W-1:0]              rem;
   logic [WORD_BITS-1:0]          row_mask;
   logic [WORD_BITS-1:0]          free_bits;
   logic [WORD_BITS-1:0]          lowest;
   logic [BIT_W-1:0]              low_pos;
   logic                          found;
   logic [PROD_W-1:0]             div_prod;
   logic [IDX_W-1:0]              bit_off;

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // clamp configuration to the map size
   always_comb begin
      total_eff = (CMP_W'(total_ff) > CMP_W'(MAX_BLOCKS)) ? MAX_C : CNT_W'(total_ff);
      res_eff   = (CMP_W'(reserved_ff) > CMP_W'(MAX_BLOCKS)) ? MAX_C : CNT_W'(reserved_ff);
      fmt_count = total_eff - ((res_eff < total_eff) ? res_eff : total_eff);
   end

   // bits of the current word that lie below a limit (reserved range or total)
   always_comb begin
      rem_src = (state_ff == S_SWEEP) ? sweep_res_ff : total_eff;
      rem     = (rem_src > base_ff) ? rem_src - base_ff : '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         row_mask[i] = CNT_W'(i) < rem;
      end
   end

   // lowest free bit of the word just read
   always_comb begin
      free_bits = ~ram_rd_data & row_mask;
      lowest    = free_bits & (~free_bits + WORD_BITS'(1));
      found     = |free_bits;
      low_pos   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         low_pos = low_pos | (lowest[i] ? BIT_W'(i) : '0);
      end
   end

   always_comb begin
      div_prod = PROD_W'(idx_ff) * PROD_W'(DIV_M);
      bit_off  = idx_ff - IDX_W'(IDX_W'(word_ff) * IDX_W'(WORD_BITS));
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      bitpos_in     = bitpos_ff;
      free_cnt_in   = free_cnt_ff;
      sweep_res_in  = sweep_res_ff;
      fmt_in        = fmt_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      total_in      = total_ff;
      reserved_in   = reserved_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = word_ff;

      if (csr_valid) begin
         unique case (csr_index)
            bba_pkg::CSR_TOTAL:    total_in    = csr_wdata;
            bba_pkg::CSR_RESERVED: reserved_in = csr_wdata;
            default:               total_in    = total_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = row_mask;
            if (word_ff == LAST_W) begin
               word_in  = '0;
               base_in  = '0;
               state_in = fmt_ff ? S_RESP : S_IDLE;
            end else begin
               word_in = word_ff + WADDR_W'(1);
               base_in = base_ff + WB_C;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               idx_in    = req_block_index;
               word_in   = '0;
               base_in   = '0;
               grant_in  = '0;
               status_in = bba_pkg::ST_OK;
               fmt_in    = 1'b0;
               unique case (req_mode)
                  bba_pkg::MODE_ALLOC: begin
                     if (total_eff == '0) begin
                        status_in = bba_pkg::ST_NORES;
                        state_in  = S_RESP;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = S_ALLOC;
                     end
                  end
                  bba_pkg::MODE_FREE: begin
                     if (CMP_W'(req_block_index) >= CMP_W'(total_eff)) begin
                        status_in = bba_pkg::ST_INVAL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_FREE_DIV;
                     end
                  end
                  bba_pkg::MODE_FORMAT: begin
                     sweep_res_in = res_eff;
                     free_cnt_in  = fmt_count;
                     fmt_in       = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  default: begin
                     status_in = bba_pkg::ST_INVAL;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // prefetch the next word while the current one is checked
            ram_rd_en   = 1'b1;
            ram_rd_addr = word_ff + WADDR_W'(1);
            if (found) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | lowest;
               grant_in    = base_ff + CNT_W'(low_pos);
               if (free_cnt_ff != '0) begin
                  free_cnt_in = free_cnt_ff - CNT_W'(1);
               end
               state_in = S_RESP;
            end else if (rem <= WB_C) begin
               status_in = bba_pkg::ST_NORES;
               state_in  = S_RESP;
            end else begin
               word_in = word_ff + WADDR_W'(1);
               base_in = base_ff + WB_C;
            end
         end
         S_FREE_DIV: begin
            word_in  = WADDR_W'(div_prod >> DIV_SH);
            state_in = S_FREE_RD;
         end
         S_FREE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = word_ff;
            bitpos_in   = BIT_W'(bit_off);
            state_in    = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (ram_rd_data[bitpos_ff]) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << bitpos_ff);
               if (free_cnt_ff != MAX_C) begin
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
               end
            end else begin
               status_in = bba_pkg::ST_INVAL;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = IDX_W'(grant_ff);
               rsp_count_in  = REG_W'(free_cnt_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         word_ff      <= '0;
         base_ff      <= '0;
         sweep_res_ff <= '0;
         fmt_ff       <= 1'b0;
         free_cnt_ff  <= MAX_C;
         total_ff     <= bba_pkg::TOTAL_RESET;
         reserved_ff  <= bba_pkg::RESERVED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         base_ff      <= base_in;
         sweep_res_ff <= sweep_res_in;
         fmt_ff       <= fmt_in;
         free_cnt_ff  <= free_cnt_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      bitpos_ff     <= bitpos_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_allocated_index = rsp_index_ff;
   assign rsp_free_count      = rsp_count_ff;

endmodule
